// ----- design/gap_pkg.sv -----
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants
// Field widths, multiplier widths, register indexes and the gain register
// bundle for the blended-gain angle PD controller.
// ----------------------------------------------------------------------------
package gap_pkg;

  localparam int GAP_AXES  = 2;   // default number of axes with stored error
  localparam int AXIS_W    = 1;
  localparam int ERR_W     = 16;  // Q2.14 angle error
  localparam int DRIVE_W   = 24;  // Q12.12 drive
  localparam int GAIN_W    = 16;  // Q8.8 gains
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: signed A x signed B, product registered
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  localparam int DIFF_W   = ERR_W + 1;       // e - previous error
  localparam int MAG_W    = ERR_W + 1;       // |e|, up to 1 << 15
  localparam int EKP_W    = ERR_W + GAIN_W + 1;
  localparam int X_W      = 43;              // e*kp + rounded rate term
  localparam int X_LO_W   = 17;              // low slice for the split multiply
  localparam int ACC_W    = 60;
  localparam int RND_W    = ACC_W - 24;
  localparam int BOUND_W  = GAIN_W + 1 + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN_SMALL     = 3'd0,
    REG_D_GAIN_SMALL     = 3'd1,
    REG_P_GAIN_LARGE     = 3'd2,
    REG_D_GAIN_LARGE     = 3'd3,
    REG_LOOP_TIME_FACTOR = 3'd4
  } gap_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] p_gain_small;
    logic [GAIN_W-1:0] d_gain_small;
    logic [GAIN_W-1:0] p_gain_large;
    logic [GAIN_W-1:0] d_gain_large;
    logic [GAIN_W-1:0] loop_time_factor;
  } gap_cfg_t;

  localparam logic [GAIN_W-1:0] P_GAIN_SMALL_RST     = 16'd2560;
  localparam logic [GAIN_W-1:0] D_GAIN_SMALL_RST     = 16'd768;
  localparam logic [GAIN_W-1:0] P_GAIN_LARGE_RST     = 16'd1280;
  localparam logic [GAIN_W-1:0] D_GAIN_LARGE_RST     = 16'd0;
  localparam logic [GAIN_W-1:0] LOOP_TIME_FACTOR_RST = 16'd256;

endpackage

// ----- design/gap_if.sv -----
// ----------------------------------------------------------------------------
// gap_if: channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface gap_in_if
  import gap_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis;
  logic signed [ERR_W-1:0]  angle_error;

  modport source (output valid, output axis, output angle_error, input ready);
  modport sink   (input valid, input axis, input angle_error, output ready);
endinterface

interface gap_out_if
  import gap_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface gap_cfg_if
  import gap_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/gap_cfg.sv -----
// ----------------------------------------------------------------------------
// gap_cfg: gain register file
// Five Q8.8 registers written over the configuration channel.
// ----------------------------------------------------------------------------
module gap_cfg
  import gap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gap_cfg_if.sink   cfg_i,
  output gap_cfg_t  regs_o
);

  gap_cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.p_gain_small     <= P_GAIN_SMALL_RST;
      regs_q.d_gain_small     <= D_GAIN_SMALL_RST;
      regs_q.p_gain_large     <= P_GAIN_LARGE_RST;
      regs_q.d_gain_large     <= D_GAIN_LARGE_RST;
      regs_q.loop_time_factor <= LOOP_TIME_FACTOR_RST;
    end else if (cfg_i.valid) begin
      // drop writes beyond the register list
      case (cfg_i.index)
        REG_P_GAIN_SMALL:     regs_q.p_gain_small     <= cfg_i.data;
        REG_D_GAIN_SMALL:     regs_q.d_gain_small     <= cfg_i.data;
        REG_P_GAIN_LARGE:     regs_q.p_gain_large     <= cfg_i.data;
        REG_D_GAIN_LARGE:     regs_q.d_gain_large     <= cfg_i.data;
        REG_LOOP_TIME_FACTOR: regs_q.loop_time_factor <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/gap_mul.sv -----
// ----------------------------------------------------------------------------
// gap_mul: shared signed multiplier
// One signed 34 x 18 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module gap_mul
  import gap_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- design/gap_core.sv -----
// ----------------------------------------------------------------------------
// gap_core: sequencer and datapath
// Walks both gain sets through the shared multiplier, accumulates the
// weighted terms, rounds, clamps and holds the result in an output register.
// ----------------------------------------------------------------------------
module gap_core
  import gap_pkg::*;
#(
  parameter int AXES = GAP_AXES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gap_in_if.sink                    in_i,
  gap_out_if.source                 out_o,
  input  gap_cfg_t                  regs_i,
  output logic signed [MUL_A_W-1:0] mul_a_o,
  output logic signed [MUL_B_W-1:0] mul_b_o,
  input  logic signed [PROD_W-1:0]  mul_p_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EP   = 4'd1;  // issue e * kp
  localparam logic [3:0] ST_DK   = 4'd2;  // issue diff * kd
  localparam logic [3:0] ST_RT   = 4'd3;  // issue (diff*kd) * loop factor
  localparam logic [3:0] ST_XS   = 4'd4;  // form e*kp + rounded rate term
  localparam logic [3:0] ST_HI   = 4'd5;  // issue x_hi * w
  localparam logic [3:0] ST_LO   = 4'd6;  // issue x_lo * w
  localparam logic [3:0] ST_RND  = 4'd7;  // round sum to Q12.12
  localparam logic [3:0] ST_CLP  = 4'd8;  // clamp and load output

  logic [3:0] state_q, state_d;
  logic       set_q, set_d;          // 0 small-error set, 1 large-error set
  logic       out_valid_q, out_valid_d;

  logic signed [ERR_W-1:0]   prev_q [AXES];
  logic signed [ERR_W-1:0]   e_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [MUL_B_W-1:0] w_small_q, w_large_q;
  logic signed [EKP_W-1:0]   ekp_q;
  logic signed [X_W-1:0]     x_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [RND_W-1:0]   rnd_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      clamped_q;

  logic                      accept;
  logic                      out_load;
  logic                      axis_ok;
  logic signed [ERR_W-1:0]   prev_sel;
  logic signed [DIFF_W-1:0]  e_ext;
  logic signed [DIFF_W-1:0]  diff_in;
  logic [MAG_W-1:0]          mag;
  logic signed [MUL_B_W-1:0] w_sel;
  logic [GAIN_W-1:0]         kp_sel, kd_sel;
  logic signed [PROD_W-1:0]  xs_sum;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic [BOUND_W-1:0]        bound;
  logic signed [RND_W-1:0]   bound_pos, bound_neg;

  assign accept   = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_CLP) && (!out_valid_q || out_o.ready);

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.drive   = drive_q;
  assign out_o.clamped = clamped_q;

  // Previous error lookup; an axis outside the store reads as zero
  always_comb begin
    prev_sel = '0;
    axis_ok  = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (32'(in_i.axis) == i) begin
        prev_sel = prev_q[i];
        axis_ok  = 1'b1;
      end
    end
  end

  assign e_ext   = {in_i.angle_error[ERR_W-1], in_i.angle_error};
  assign diff_in = e_ext - {prev_sel[ERR_W-1], prev_sel};
  assign mag     = in_i.angle_error[ERR_W-1] ? MAG_W'(-e_ext) : MAG_W'(e_ext);

  assign w_sel  = set_q ? w_large_q : w_small_q;
  assign kp_sel = set_q ? regs_i.p_gain_large : regs_i.p_gain_small;
  assign kd_sel = set_q ? regs_i.d_gain_large : regs_i.d_gain_small;

  // floor((r + 128) / 256) + ekp folded into a single shift
  assign xs_sum = mul_p_i
                + {{(PROD_W-EKP_W-8){ekp_q[EKP_W-1]}}, ekp_q, 8'd0}
                + PROD_W'(128);

  assign rnd_sum = acc_q
                 + {{(ACC_W-PROD_W){mul_p_i[PROD_W-1]}}, mul_p_i}
                 + ACC_W'(1 << 23);

  assign bound     = {({1'b0, regs_i.p_gain_small} + {1'b0, regs_i.p_gain_large}), 4'd0};
  assign bound_pos = RND_W'(bound);
  assign bound_neg = -bound_pos;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    case (state_q)
      ST_EP: begin
        mul_a_o = MUL_A_W'(e_q);
        mul_b_o = {2'b00, kp_sel};
      end
      ST_DK: begin
        mul_a_o = MUL_A_W'(diff_q);
        mul_b_o = {2'b00, kd_sel};
      end
      ST_RT: begin
        mul_a_o = mul_p_i[MUL_A_W-1:0];
        mul_b_o = {2'b00, regs_i.loop_time_factor};
      end
      ST_HI: begin
        mul_a_o = MUL_A_W'($signed(x_q[X_W-1:X_LO_W]));
        mul_b_o = w_sel;
      end
      ST_LO: begin
        mul_a_o = {{(MUL_A_W-X_LO_W){1'b0}}, x_q[X_LO_W-1:0]};
        mul_b_o = w_sel;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    set_d       = set_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EP;
          set_d   = 1'b0;
        end
      end
      ST_EP:  state_d = ST_DK;
      ST_DK:  state_d = ST_RT;
      ST_RT:  state_d = ST_XS;
      ST_XS:  state_d = ST_HI;
      ST_HI:  state_d = ST_LO;
      ST_LO: begin
        if (set_q) begin
          state_d = ST_RND;
        end else begin
          state_d = ST_EP;
          set_d   = 1'b1;
        end
      end
      ST_RND: state_d = ST_CLP;
      ST_CLP: begin
        if (out_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      set_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      set_q       <= set_d;
      out_valid_q <= out_valid_d;
      if (accept && axis_ok) begin
        for (int i = 0; i < AXES; i++) begin
          if (32'(in_i.axis) == i) begin
            prev_q[i] <= in_i.angle_error;
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          e_q       <= in_i.angle_error;
          diff_q    <= diff_in;
          w_small_q <= MUL_B_W'(16384) - MUL_B_W'(mag);
          w_large_q <= MUL_B_W'(mag);
          acc_q     <= '0;
        end
      end
      ST_EP: begin
        // fold in the low product of the small-error set
        if (set_q) begin
          acc_q <= acc_q + {{(ACC_W-PROD_W){mul_p_i[PROD_W-1]}}, mul_p_i};
        end
      end
      ST_DK:  ekp_q <= mul_p_i[EKP_W-1:0];
      ST_XS:  x_q   <= xs_sum[X_W+7:8];
      ST_LO: begin
        acc_q <= acc_q + {mul_p_i[ACC_W-X_LO_W-1:0], {X_LO_W{1'b0}}};
      end
      ST_RND: rnd_q <= rnd_sum[ACC_W-1:24];
      ST_CLP: begin
        if (out_load) begin
          if (rnd_q > bound_pos) begin
            drive_q   <= bound_pos[DRIVE_W-1:0];
            clamped_q <= 1'b1;
          end else if (rnd_q < bound_neg) begin
            drive_q   <= bound_neg[DRIVE_W-1:0];
            clamped_q <= 1'b1;
          end else begin
            drive_q   <= rnd_q[DRIVE_W-1:0];
            clamped_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // An accepted item always starts on the small-error set
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EP) && !set_q)
    else $error("sequence did not start on the small-error set");

  // Drive never leaves the clamp bound
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (RND_W'(out_o.drive) <= bound_pos)
                 && (RND_W'(out_o.drive) >= bound_neg))
    else $error("drive outside clamp bound");

  // A clamped result sits exactly on the bound
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.clamped) |-> (RND_W'(out_o.drive) == bound_pos)
                                    || (RND_W'(out_o.drive) == bound_neg))
    else $error("clamped result not on the bound");

  // Rounding always follows the large-error set
  a_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND) |-> $past(state_q == ST_LO) && set_q)
    else $error("rounding entered out of order");

endmodule

// ----- design/blended_gain_angle_pd.sv -----
// ----------------------------------------------------------------------------
// blended_gain_angle_pd: per-axis leveling PD controller with blended gains
// Top level: gain registers, shared multiplier and the sequencing core.
// ----------------------------------------------------------------------------
// Each accepted transaction carries an axis and a signed Q2.14 angle error e.
// The result is drive = sum over both gain sets of w * (e*kp + rate), with
// rate = (e - previous error) * kd * loop_time_factor rounded to Q22,
// w = 1 - |e| for the small-error set and |e| for the large-error set (the
// small weight goes negative above |e| = 1.0). The sum is rounded half up to
// Q12.12 and clamped to +-(p_gain_small + p_gain_large); clamped flags a
// limited result. The previous error per axis resets to zero; an axis at or
// beyond AXES uses zero and stores nothing. The input is ready only when
// idle. After acceptance the core issues five products per gain set through
// one 34 x 18 multiplier, then rounds and clamps the sum into the output
// register, so a transaction is accepted only after the previous one has
// been loaded there. A result waiting in the output register does not
// block acceptance of the next transaction.
// Write the gain registers only while the block is idle.
// ----------------------------------------------------------------------------
module blended_gain_angle_pd
  import gap_pkg::*;
#(
  parameter int AXES = GAP_AXES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gap_in_if.sink     in_i,
  gap_out_if.source  out_o,
  gap_cfg_if.sink    cfg_i
);

  gap_cfg_t                  regs;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Gain registers, always ready for a write
  gap_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // One multiplier shared by every product of the item
  gap_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Sequencer, accumulator, error store and output register
  gap_core #(
    .AXES (AXES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .regs_i  (regs),
    .mul_a_o (mul_a),
    .mul_b_o (mul_b),
    .mul_p_i (mul_p)
  );

endmodule

// ----- bench/gap_drive_checker.sv -----
// ----------------------------------------------------------------------------
// gap_drive_checker: drive prediction and result comparison
// Watches the input, result and register channels of the blended-gain angle
// PD controller, predicts drive and clamped for every accepted transaction
// and compares each result against the oldest prediction still open.
// ----------------------------------------------------------------------------
module gap_drive_checker
  import gap_pkg::*;
#(
  parameter int AXES = GAP_AXES
) (
  input  logic clk_i,
  input  logic rst_ni,
  gap_in_if    in_i,
  gap_out_if   out_i,
  gap_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q14 = longint'(1) << (ERR_W - 2);

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_result_t;

  drive_result_t expected_drive_q[$];
  gap_cfg_t      gains;
  longint        last_error [AXES];

  // Round half up: add half an LSB, then floor by arithmetic shift
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // One gain set: (e*kp + rate) scaled by its blend weight, in Q36
  function automatic longint blended_term(longint e, longint diff, longint w,
                                          logic [GAIN_W-1:0] kp,
                                          logic [GAIN_W-1:0] kd);
    longint rate;
    rate = round_half_up(diff * longint'(kd) * longint'(gains.loop_time_factor), 8);
    return e * longint'(kp) * w + rate * w;
  endfunction

  // Predict one result and advance the stored error of the axis
  function automatic drive_result_t predict_drive(logic [AXIS_W-1:0] axis,
                                                  logic signed [ERR_W-1:0] err);
    drive_result_t r;
    longint e, prev, mag, diff, sum, level, bound;
    e     = err;
    prev  = (int'(axis) < AXES) ? last_error[axis] : 0;
    mag   = (e < 0) ? -e : e;
    diff  = e - prev;
    sum   = blended_term(e, diff, ONE_Q14 - mag, gains.p_gain_small, gains.d_gain_small)
          + blended_term(e, diff, mag, gains.p_gain_large, gains.d_gain_large);
    level = round_half_up(sum, 24);
    bound = (longint'(gains.p_gain_small) + longint'(gains.p_gain_large)) * 16;
    r.clamped = 1'b0;
    if (level > bound) begin
      level     = bound;
      r.clamped = 1'b1;
    end else if (level < -bound) begin
      level     = -bound;
      r.clamped = 1'b1;
    end
    if (int'(axis) < AXES) begin
      last_error[axis] = e;
    end
    r.drive = level[DRIVE_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    drive_result_t exp_r;
    if (!rst_ni) begin
      gains.p_gain_small     = P_GAIN_SMALL_RST;
      gains.d_gain_small     = D_GAIN_SMALL_RST;
      gains.p_gain_large     = P_GAIN_LARGE_RST;
      gains.d_gain_large     = D_GAIN_LARGE_RST;
      gains.loop_time_factor = LOOP_TIME_FACTOR_RST;
      for (int a = 0; a < AXES; a++) begin
        last_error[a] = 0;
      end
      expected_drive_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_P_GAIN_SMALL:     gains.p_gain_small     = cfg_i.data;
          REG_D_GAIN_SMALL:     gains.d_gain_small     = cfg_i.data;
          REG_P_GAIN_LARGE:     gains.p_gain_large     = cfg_i.data;
          REG_D_GAIN_LARGE:     gains.d_gain_large     = cfg_i.data;
          REG_LOOP_TIME_FACTOR: gains.loop_time_factor = cfg_i.data;
          default: ;
        endcase
      end
      // Compare first: a result can never belong to a transaction taken this edge
      if (out_i.valid && out_i.ready) begin
        if (expected_drive_q.size() == 0) begin
          $error("result with no transaction pending: drive %0d clamped %0b",
                 out_i.drive, out_i.clamped);
          fail_count_o++;
        end else begin
          exp_r = expected_drive_q.pop_front();
          if (out_i.drive !== exp_r.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", exp_r.drive, out_i.drive);
            fail_count_o++;
          end
          if (out_i.clamped !== exp_r.clamped) begin
            $error("clamped mismatch: expected %0b, actual %0b",
                   exp_r.clamped, out_i.clamped);
            fail_count_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_drive_q.push_back(predict_drive(in_i.axis, in_i.angle_error));
      end
    end
    pending_o = expected_drive_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the blended-gain angle PD controller
// Drives angle errors on both axes through directed corner cases and random
// phases under changing gain settings, stalls the result side at random, and
// lets gap_drive_checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb_top
  import gap_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 15;
  localparam int PHASE_ITEMS     = 100;
  // Settling wait once every result has been taken
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int ERR_MAX         = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_MIN         = -(1 << (ERR_W - 1));
  localparam int ONE_Q14         = 1 << (ERR_W - 2);
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count;

  // Pacing knobs shared between the stimulus and the result-side process
  bit tx_steady;
  bit rx_steady;
  bit hold_off_req;

  // Per-axis random walk so nearly half the errors move like a real leveling loop
  int walk_err [2];

  gap_in_if  in_ch ();
  gap_out_if out_ch ();
  gap_cfg_if cfg_ch ();

  blended_gain_angle_pd u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  gap_drive_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Idle stretch: mostly a few cycles, sometimes tens, rarely over a hundred
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      return $urandom_range(3, 1);
    end else if (pick < 97) begin
      return $urandom_range(20, 4);
    end
    return $urandom_range(120, 30);
  endfunction

  // Gain value: extremes now and then, modest gains mostly, full range too
  function automatic logic [GAIN_W-1:0] draw_gain();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 20) begin
      return GAIN_MAX;
    end else if (pick < 70) begin
      return GAIN_W'($urandom_range(2047));
    end
    return GAIN_W'($urandom);
  endfunction

  // Angle error for one axis: random walk, near unit magnitude, raw or extreme
  function automatic logic signed [ERR_W-1:0] draw_error(int ax);
    int pick;
    int val;
    pick = $urandom_range(99);
    if (pick < 45) begin
      val = walk_err[ax] + int'($urandom_range(1024)) - 512;
      if (val > ERR_MAX) val = ERR_MAX;
      if (val < ERR_MIN) val = ERR_MIN;
    end else if (pick < 65) begin
      val = ONE_Q14 + int'($urandom_range(128)) - 64;
      if ($urandom_range(1)) val = -val;
    end else if (pick < 90) begin
      val = int'($signed(ERR_W'($urandom)));
    end else begin
      case ($urandom_range(2))
        0:       val = ERR_MIN;
        1:       val = ERR_MAX;
        default: val = 0;
      endcase
    end
    walk_err[ax] = val;
    return ERR_W'(val);
  endfunction

  // Offer one transaction from a falling edge, hold until taken, then maybe idle.
  // Leave valid high when no gap follows so back-to-back offers stay clean.
  task automatic send_item(input logic [AXIS_W-1:0] ax, input logic signed [ERR_W-1:0] er);
    int gap;
    in_ch.axis        <= ax;
    in_ch.angle_error <= er;
    in_ch.valid       <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    gap = (tx_steady || $urandom_range(1)) ? 0 : idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Register write; the caller drops valid after the last one of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] p_small, input logic [GAIN_W-1:0] d_small,
                             input logic [GAIN_W-1:0] p_large, input logic [GAIN_W-1:0] d_large,
                             input logic [GAIN_W-1:0] time_factor);
    write_reg(REG_P_GAIN_SMALL, p_small);
    write_reg(REG_D_GAIN_SMALL, d_small);
    write_reg(REG_P_GAIN_LARGE, p_large);
    write_reg(REG_D_GAIN_LARGE, d_large);
    write_reg(REG_LOOP_TIME_FACTOR, time_factor);
    // Occasionally hit the unused indexes; the block must ignore them
    if ($urandom_range(3) == 0) begin
      for (int k = int'(REG_LOOP_TIME_FACTOR) + 1; k < (1 << CFG_IDX_W); k++) begin
        write_reg(CFG_IDX_W'(k), draw_gain());
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Result side: random ready with short and long stalls, steady stretches,
  // and one long hold-off counted here so the block backs up into its input
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_steady || $urandom_range(99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_left   = idle_length() - 1;
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if it takes far longer than any correct run could
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.axis        = '0;
    in_ch.angle_error = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    tx_steady         = 1'b0;
    rx_steady         = 1'b0;
    hold_off_req      = 1'b0;
    walk_err[0]       = 0;
    walk_err[1]       = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset gains: unit magnitude zeroes the small-set weight, beyond unit
    // it goes negative; full-scale swings give the largest error differences
    send_item(1'b0, ERR_W'(ONE_Q14));
    send_item(1'b0, ERR_W'(-ONE_Q14));
    send_item(1'b1, ERR_W'(ONE_Q14 + 1));
    send_item(1'b1, ERR_W'(ERR_MIN));
    send_item(1'b0, ERR_W'(ERR_MAX));
    send_item(1'b1, ERR_W'(ERR_MAX));
    send_item(1'b0, ERR_W'(ERR_MIN));
    send_item(1'b0, '0);
    send_item(1'b1, ERR_W'(1));
    send_item(1'b1, ERR_W'(-1));

    // All gains at full scale: the clamp engages on both signs
    wait_idle();
    write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_item(1'b0, ERR_W'(ERR_MAX));
    send_item(1'b0, ERR_W'(ERR_MIN));
    send_item(1'b1, '0);
    send_item(1'b1, ERR_W'(ONE_Q14));
    send_item(1'b1, ERR_W'(-ONE_Q14 - 1));

    // Writes to unused indexes must leave the gains alone
    wait_idle();
    for (int k = int'(REG_LOOP_TIME_FACTOR) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), '0);
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    send_item(1'b0, ERR_W'(ONE_Q14 / 2));

    // Zero gains: the bound collapses and drive must be zero
    wait_idle();
    write_gains('0, '0, '0, '0, '0);
    send_item(1'b0, ERR_W'(12345));
    send_item(1'b1, ERR_W'(ERR_MIN));
    send_item(1'b0, ERR_W'(-ONE_Q14));

    // Random phases, each under fresh gains, with varied pacing
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      write_gains(draw_gain(), draw_gain(), draw_gain(), draw_gain(), draw_gain());
      @(negedge clk_i);
      tx_steady = (phase % 4 == 1) || (phase == 3);
      rx_steady = (phase % 4 == 2);
      // Hold off the result side while offering back to back
      if (phase == 3) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        int ax;
        ax = $urandom_range(1);
        send_item(AXIS_W'(ax), draw_error(ax));
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- blended_gain_angle_pd.f -----
design/gap_pkg.sv
design/gap_if.sv
design/gap_cfg.sv
design/gap_mul.sv
design/gap_core.sv
design/blended_gain_angle_pd.sv
bench/gap_drive_checker.sv
bench/tb_top.sv
